// ===== hw/rtl/root_stack_mark_sweep_collector_defines.svh =====
`ifndef ROOT_STACK_MARK_SWEEP_COLLECTOR_DEFINES_SVH
`define ROOT_STACK_MARK_SWEEP_COLLECTOR_DEFINES_SVH

// property that must hold at every clock edge out of reset
`define RSMC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// consequence must hold in the cycle after the antecedent
`define RSMC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/rsmc_pkg.sv =====
package rsmc_pkg;

    // table and stack geometry
    localparam int SLOTS        = 32;
    localparam int STACK_DEPTH  = 16;
    localparam int PAYLOAD_BITS = 32;

    // fixed field widths
    localparam int PAYLOAD_W = 32;
    localparam int COUNT_W   = 6;
    localparam int THR_W     = 6;
    localparam int CODE_W    = 3;
    localparam int KIND_W    = 2;

    // derived widths
    localparam int STORE_BITS = (PAYLOAD_BITS < PAYLOAD_W) ? PAYLOAD_BITS : PAYLOAD_W;
    localparam int SLOT_W     = $clog2(SLOTS);
    localparam int LIVE_W     = $clog2(SLOTS + 1);
    localparam int SP_W       = $clog2(STACK_DEPTH + 1);
    localparam int SIDX_W     = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    // configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic [0:0] REG_INIT_THR = 1'b0;
    localparam logic [THR_W-1:0] THR_RESET = THR_W'(8);

    typedef enum logic [KIND_W-1:0] {
        K_PUSH    = 2'd0,
        K_POP     = 2'd1,
        K_COLLECT = 2'd2,
        K_RELEASE = 2'd3
    } t_kind;

    typedef enum logic [CODE_W-1:0] {
        RC_PUSHED = 3'd0,
        RC_POPPED = 3'd1,
        RC_FREED  = 3'd2,
        RC_DONE   = 3'd3,
        RC_ERROR  = 3'd4
    } t_code;

    typedef struct packed {
        t_kind                kind;
        logic [PAYLOAD_W-1:0] payload;
    } t_in_item;

    typedef struct packed {
        t_code                result_code;
        logic [PAYLOAD_W-1:0] payload_res;
        logic [COUNT_W-1:0]   live_count;
        logic                 last;
    } t_out_item;

endpackage

// ===== hw/rtl/root_stack_mark_sweep_collector.sv =====
// channel  | direction | handshake                   | item
// ---------+-----------+-----------------------------+---------------------------------
// in       | input     | i_in_valid / o_in_stall     | rsmc_pkg::t_in_item  (kind, payload)
// out      | output    | o_out_valid / i_out_stall   | rsmc_pkg::t_out_item (code, payload,
//          |           |                             |   live count, last)
// apb      | input     | psel / penable / pready     | initial_threshold at byte address 0
//
// One item at a time; slot payloads and root stack sit in synchronous-read memories.
// Push: an allocation step; pop: stack read, then payload read. A collection marks from
// the stack entries, sweeps every slot with a free step per freed item, then finishes;
// a push that triggers a collection runs it before its allocation step.
// Reset is synchronous and clears the live and mark bits, the stack pointer and counts;
// no clearing pass is needed. An output stall holds the sequencer at its next result.
`include "root_stack_mark_sweep_collector_defines.svh"

module root_stack_mark_sweep_collector (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // item input
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  rsmc_pkg::t_in_item                  i_in_data,
    // result output
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output rsmc_pkg::t_out_item                 o_out_data,
    // configuration
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [rsmc_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [rsmc_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [rsmc_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);

    localparam int SLOTS       = rsmc_pkg::SLOTS;
    localparam int STACK_DEPTH = rsmc_pkg::STACK_DEPTH;
    localparam int STORE_BITS  = rsmc_pkg::STORE_BITS;
    localparam int SLOT_W      = rsmc_pkg::SLOT_W;
    localparam int LIVE_W      = rsmc_pkg::LIVE_W;
    localparam int SP_W        = rsmc_pkg::SP_W;
    localparam int SIDX_W      = rsmc_pkg::SIDX_W;
    localparam int COUNT_W     = rsmc_pkg::COUNT_W;
    localparam int THR_W       = rsmc_pkg::THR_W;
    localparam int PAYLOAD_W   = rsmc_pkg::PAYLOAD_W;
    localparam int APB_DATA_W  = rsmc_pkg::APB_DATA_W;

    typedef enum logic [8:0] {
        S_IDLE     = 9'b000000001,
        S_ERR      = 9'b000000010,
        S_MARK     = 9'b000000100,
        S_SWEEP    = 9'b000001000,
        S_FREE     = 9'b000010000,
        S_DONE     = 9'b000100000,
        S_ALLOC    = 9'b001000000,
        S_POP_SLOT = 9'b010000000,
        S_POP_OUT  = 9'b100000000
    } t_state;

    // control state
    t_state                  r_state;
    logic                    r_out_valid;
    rsmc_pkg::t_out_item     r_out;
    logic [SLOTS-1:0]        r_live;
    logic [SLOTS-1:0]        r_mark;
    logic [SP_W-1:0]         r_sp;
    logic [LIVE_W-1:0]       r_live_total;
    logic [THR_W-1:0]        r_init_thr;
    logic [THR_W-1:0]        r_thr;
    logic                    r_push;
    logic [SP_W-1:0]         r_midx;
    logic                    r_mpend;
    logic [SLOT_W-1:0]       r_sidx;
    logic                    r_pop_live;
    logic [STORE_BITS-1:0]   r_pay;

    // memories
    logic [STORE_BITS-1:0]   r_pmem [SLOTS];
    logic [SLOT_W-1:0]       r_smem [STACK_DEPTH];
    logic [STORE_BITS-1:0]   r_pm_rdata;
    logic [SLOT_W-1:0]       r_sm_rdata;

    logic                    pm_we;
    logic                    pm_re;
    logic [SLOT_W-1:0]       pm_raddr;
    logic                    sm_we;
    logic                    sm_re;
    logic [SIDX_W-1:0]       sm_raddr;

    logic                    out_free;
    logic                    in_acc;
    logic                    cfg_wr;
    logic [SLOTS-1:0]        lowest_free;
    logic                    have_free;
    logic [SLOT_W-1:0]       free_idx;
    logic                    sweep_hit;
    logic                    sweep_end;
    logic                    pop_ok;
    logic [SP_W-1:0]         sp_dec;
    logic [LIVE_W+1:0]       live_x3;
    logic [THR_W-1:0]        thr_next;
    logic [COUNT_W-1:0]      live_cnt;
    logic                    out_load;
    logic                    out_load_last;

    // one-hot to index
    function automatic logic [SLOT_W-1:0] enc_slot(input logic [SLOTS-1:0] oh);
        logic [SLOT_W-1:0] idx;
        idx = '0;
        for (int k = 0; k < SLOTS; k++) begin
            if (oh[k]) begin
                idx = idx | SLOT_W'(k);
            end
        end
        return idx;
    endfunction

    function automatic rsmc_pkg::t_out_item mk_out(input rsmc_pkg::t_code code,
                                                  input logic [PAYLOAD_W-1:0] pay,
                                                  input logic [COUNT_W-1:0] cnt,
                                                  input logic lst);
        rsmc_pkg::t_out_item o;
        o.result_code = code;
        o.payload_res = pay;
        o.live_count  = cnt;
        o.last        = lst;
        return o;
    endfunction

    // handshake and config decode
    assign out_free   = !r_out_valid || !i_out_stall;
    assign in_acc     = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);
    assign cfg_wr     = psel && penable && pwrite && (paddr[2:2] == rsmc_pkg::REG_INIT_THR);
    assign pready     = 1'b1;
    assign prdata     = (paddr[2:2] == rsmc_pkg::REG_INIT_THR) ? APB_DATA_W'(r_init_thr) : '0;

    // lowest free slot: lowest zero bit of the live vector
    assign lowest_free = ~r_live & (r_live + SLOTS'(1));
    assign have_free   = |lowest_free;
    assign free_idx    = enc_slot(lowest_free);

    assign sweep_hit = r_live[r_sidx] && !r_mark[r_sidx];
    assign sweep_end = (r_sidx == SLOT_W'(SLOTS - 1));
    assign pop_ok    = ({1'b0, r_sm_rdata} < (SLOT_W + 1)'(SLOTS)) && r_live[r_sm_rdata];
    assign sp_dec    = r_sp - SP_W'(1);
    assign live_cnt  = COUNT_W'(r_live_total);

    // threshold after a collection: live * 3 / 2
    assign live_x3  = (LIVE_W + 2)'({r_live_total, 1'b0}) + (LIVE_W + 2)'(r_live_total);
    assign thr_next = THR_W'(live_x3[LIVE_W+1:1]);

    // result register loads
    assign out_load = out_free && ((r_state == S_ERR) || (r_state == S_FREE)
                                   || (r_state == S_ALLOC) || (r_state == S_POP_OUT)
                                   || ((r_state == S_DONE) && !r_push));
    assign out_load_last = out_load && (r_state != S_FREE);

    // memory access control
    assign pm_we    = (r_state == S_ALLOC) && out_free && have_free;
    assign pm_re    = ((r_state == S_SWEEP) && sweep_hit) || (r_state == S_POP_SLOT);
    assign pm_raddr = (r_state == S_POP_SLOT) ? r_sm_rdata : r_sidx;
    assign sm_we    = pm_we;
    assign sm_re    = (in_acc && (i_in_data.kind == rsmc_pkg::K_POP) && (r_sp != '0))
                      || ((r_state == S_MARK) && (r_midx < r_sp));
    assign sm_raddr = (r_state == S_MARK) ? r_midx[SIDX_W-1:0] : sp_dec[SIDX_W-1:0];

    // slot payload memory
    always_ff @(posedge i_clk) begin
        if (pm_we) begin
            r_pmem[free_idx] <= r_pay;
        end
        if (pm_re) begin
            r_pm_rdata <= r_pmem[pm_raddr];
        end
    end

    // root stack memory
    always_ff @(posedge i_clk) begin
        if (sm_we) begin
            r_smem[r_sp[SIDX_W-1:0]] <= free_idx;
        end
        if (sm_re) begin
            r_sm_rdata <= r_smem[sm_raddr];
        end
    end

    // push payload holding register
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_pay <= i_in_data.payload[STORE_BITS-1:0];
        end
    end

    // result register payload
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            case (r_state)
                S_FREE: begin
                    r_out <= mk_out(rsmc_pkg::RC_FREED, PAYLOAD_W'(r_pm_rdata),
                                    COUNT_W'(r_live_total - LIVE_W'(1)), 1'b0);
                end
                S_DONE: begin
                    r_out <= mk_out(rsmc_pkg::RC_DONE, '0, live_cnt, 1'b1);
                end
                S_ALLOC: begin
                    if (have_free) begin
                        r_out <= mk_out(rsmc_pkg::RC_PUSHED, '0,
                                        COUNT_W'(r_live_total + LIVE_W'(1)), 1'b1);
                    end else begin
                        r_out <= mk_out(rsmc_pkg::RC_ERROR, '0, live_cnt, 1'b1);
                    end
                end
                S_POP_OUT: begin
                    r_out <= mk_out(rsmc_pkg::RC_POPPED,
                                    r_pop_live ? PAYLOAD_W'(r_pm_rdata) : '0,
                                    live_cnt, 1'b1);
                end
                default: begin
                    r_out <= mk_out(rsmc_pkg::RC_ERROR, '0, live_cnt, 1'b1);
                end
            endcase
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_out_valid  <= 1'b0;
            r_live       <= '0;
            r_mark       <= '0;
            r_sp         <= '0;
            r_live_total <= '0;
            r_init_thr   <= rsmc_pkg::THR_RESET;
            r_thr        <= rsmc_pkg::THR_RESET;
            r_push       <= 1'b0;
            r_midx       <= '0;
            r_mpend      <= 1'b0;
            r_sidx       <= '0;
            r_pop_live   <= 1'b0;
        end else begin
            // result register drains when taken
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            // threshold register write
            if (cfg_wr) begin
                r_init_thr <= pwdata[THR_W-1:0];
                r_thr      <= pwdata[THR_W-1:0];
            end

            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_midx  <= '0;
                        r_mpend <= 1'b0;
                        case (i_in_data.kind)
                            rsmc_pkg::K_PUSH: begin
                                r_push <= 1'b1;
                                if (r_sp >= SP_W'(STACK_DEPTH)) begin
                                    r_state <= S_ERR;
                                end else if (live_cnt == r_thr) begin
                                    r_state <= S_MARK;
                                end else begin
                                    r_state <= S_ALLOC;
                                end
                            end
                            rsmc_pkg::K_POP: begin
                                r_push <= 1'b0;
                                if (r_sp == '0) begin
                                    r_state <= S_ERR;
                                end else begin
                                    r_sp    <= sp_dec;
                                    r_state <= S_POP_SLOT;
                                end
                            end
                            rsmc_pkg::K_COLLECT: begin
                                r_push  <= 1'b0;
                                r_state <= S_MARK;
                            end
                            rsmc_pkg::K_RELEASE: begin
                                r_push  <= 1'b0;
                                r_sp    <= '0;
                                r_state <= S_MARK;
                            end
                            default: begin
                                r_state <= S_ERR;
                            end
                        endcase
                    end
                end

                S_ERR: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end

                // mark: stream stack entries, mark each one in the cycle after its read
                S_MARK: begin
                    if (r_mpend && ({1'b0, r_sm_rdata} < (SLOT_W + 1)'(SLOTS))) begin
                        r_mark[r_sm_rdata] <= 1'b1;
                    end
                    if (r_midx < r_sp) begin
                        r_midx  <= r_midx + SP_W'(1);
                        r_mpend <= 1'b1;
                    end else begin
                        r_mpend <= 1'b0;
                        if (!r_mpend) begin
                            r_sidx  <= '0;
                            r_state <= S_SWEEP;
                        end
                    end
                end

                // sweep: one slot a cycle, but each slot to free waits in the free step, which reads its payload
                S_SWEEP: begin
                    if (sweep_hit) begin
                        r_state <= S_FREE;
                    end else if (sweep_end) begin
                        r_state <= S_DONE;
                    end else begin
                        r_sidx <= r_sidx + SLOT_W'(1);
                    end
                end

                S_FREE: begin
                    if (out_free) begin
                        r_live[r_sidx] <= 1'b0;
                        r_live_total   <= r_live_total - LIVE_W'(1);
                        if (sweep_end) begin
                            r_state <= S_DONE;
                        end else begin
                            r_sidx  <= r_sidx + SLOT_W'(1);
                            r_state <= S_SWEEP;
                        end
                    end
                end

                // end of collection: clear marks, new threshold
                S_DONE: begin
                    r_mark <= '0;
                    r_thr  <= thr_next;
                    if (r_push) begin
                        r_state <= S_ALLOC;
                    end else if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end

                S_ALLOC: begin
                    if (out_free) begin
                        if (have_free) begin
                            r_live[free_idx] <= 1'b1;
                            r_live_total     <= r_live_total + LIVE_W'(1);
                            r_sp             <= r_sp + SP_W'(1);
                        end
                        r_state <= S_IDLE;
                    end
                end

                S_POP_SLOT: begin
                    r_pop_live <= pop_ok;
                    r_state    <= S_POP_OUT;
                end

                S_POP_OUT: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // checks
    `RSMC_ASSERT(a_live_total, r_live_total == LIVE_W'($countones(r_live)), "live count off")
    `RSMC_ASSERT(a_stack_bound, r_sp <= SP_W'(STACK_DEPTH), "stack pointer beyond depth")
    `RSMC_ASSERT(a_marks_clear_idle, (r_state != S_IDLE) || (r_mark == '0), "marks left set")
    `RSMC_ASSERT_NEXT(a_last_ends_item, out_load_last, r_state == S_IDLE, "last result not final")

endmodule

// ===== verif/root_stack_mark_sweep_collector_test.sv =====
module root_stack_mark_sweep_collector_test;

    localparam int SLOTS       = rsmc_pkg::SLOTS;
    localparam int STACK_DEPTH = rsmc_pkg::STACK_DEPTH;
    localparam int STORE_BITS  = rsmc_pkg::STORE_BITS;
    localparam int SLOT_W      = rsmc_pkg::SLOT_W;
    localparam int COUNT_W     = rsmc_pkg::COUNT_W;
    localparam int THR_W       = rsmc_pkg::THR_W;
    localparam int PAYLOAD_W   = rsmc_pkg::PAYLOAD_W;
    localparam int APB_ADDR_W  = rsmc_pkg::APB_ADDR_W;
    localparam int APB_DATA_W  = rsmc_pkg::APB_DATA_W;

    localparam int CYCLE_LIMIT = 600000;
    localparam int HOLD_CYCLES = 400;
    localparam int TAIL_CYCLES = 120;
    localparam logic [APB_ADDR_W-1:0] THR_ADDR   = APB_ADDR_W'(4 * rsmc_pkg::REG_INIT_THR);
    localparam logic [APB_ADDR_W-1:0] SPARE_ADDR = THR_ADDR + APB_ADDR_W'(4);
    localparam logic [PAYLOAD_W-1:0]  KEEP_MASK  =
        {PAYLOAD_W{1'b1}} >> (PAYLOAD_W - STORE_BITS);

    logic                  clk;
    logic                  rst_n    = 1'b0;
    logic                  in_valid = 1'b0;
    rsmc_pkg::t_in_item    in_item  = '0;
    logic                  in_stall;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    rsmc_pkg::t_out_item   out_item;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0] paddr    = '0;
    logic [APB_DATA_W-1:0] pwdata   = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // shadow of the object table, root stack and counters
    logic [PAYLOAD_W-1:0] slot_data [SLOTS];
    bit                   slot_used [SLOTS];
    logic [SLOT_W-1:0]    root_slot [STACK_DEPTH];
    int                   root_depth;
    int                   live_objs;
    int                   gc_limit;

    rsmc_pkg::t_in_item  item_backlog [$];
    rsmc_pkg::t_out_item expected_results [$];
    rsmc_pkg::t_out_item want_r;

    int send_idle_pct = 0;
    int stall_pct     = 0;
    int hold_asked    = 0;
    int hold_served   = 0;
    int hold_left     = 0;
    int mismatches    = 0;
    int cycle_count   = 0;

    root_stack_mark_sweep_collector u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_item),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // one result with the live count as it stands now
    function automatic void add_expected(rsmc_pkg::t_code code, logic [PAYLOAD_W-1:0] pay);
        rsmc_pkg::t_out_item r;
        r.result_code = code;
        r.payload_res = pay;
        r.live_count  = COUNT_W'(live_objs);
        r.last        = 1'b0;
        expected_results.push_back(r);
    endfunction

    // mark from the stack, free unmarked live slots in slot order, set the new limit
    function automatic void sweep_table();
        bit marked [SLOTS];
        for (int i = 0; i < SLOTS; i++) marked[i] = 1'b0;
        for (int i = 0; i < root_depth; i++) marked[root_slot[i]] = 1'b1;
        for (int i = 0; i < SLOTS; i++) begin
            if (slot_used[i] && !marked[i]) begin
                slot_used[i] = 1'b0;
                live_objs--;
                add_expected(rsmc_pkg::RC_FREED, slot_data[i]);
            end
        end
        gc_limit = (live_objs * 3 / 2) % 64;
    endfunction

    // results caused by one accepted item
    function automatic void predict_item(rsmc_pkg::t_in_item it);
        int                  free_slot;
        rsmc_pkg::t_out_item r;
        free_slot = -1;
        case (it.kind)
            rsmc_pkg::K_PUSH: begin
                if (root_depth >= STACK_DEPTH) begin
                    add_expected(rsmc_pkg::RC_ERROR, '0);
                end else begin
                    if (live_objs == gc_limit) sweep_table();
                    for (int i = SLOTS - 1; i >= 0; i--) begin
                        if (!slot_used[i]) free_slot = i;
                    end
                    if (free_slot < 0) begin
                        add_expected(rsmc_pkg::RC_ERROR, '0);
                    end else begin
                        slot_used[free_slot] = 1'b1;
                        slot_data[free_slot] = it.payload & KEEP_MASK;
                        live_objs++;
                        root_slot[root_depth] = SLOT_W'(free_slot);
                        root_depth++;
                        add_expected(rsmc_pkg::RC_PUSHED, '0);
                    end
                end
            end
            rsmc_pkg::K_POP: begin
                if (root_depth == 0) begin
                    add_expected(rsmc_pkg::RC_ERROR, '0);
                end else begin
                    root_depth--;
                    add_expected(rsmc_pkg::RC_POPPED, slot_used[root_slot[root_depth]] ?
                                 slot_data[root_slot[root_depth]] : '0);
                end
            end
            default: begin
                if (it.kind == rsmc_pkg::K_RELEASE) root_depth = 0;
                sweep_table();
                add_expected(rsmc_pkg::RC_DONE, '0);
            end
        endcase
        r = expected_results[$];
        r.last = 1'b1;
        expected_results[expected_results.size() - 1] = r;
    endfunction

    // item driver, also tracks register writes on the bus
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            root_depth = 0;
            live_objs  = 0;
            gc_limit   = int'(rsmc_pkg::THR_RESET);
            for (int i = 0; i < SLOTS; i++) slot_used[i] = 1'b0;
        end else begin
            if (psel && penable && pwrite && pready && paddr == THR_ADDR)
                gc_limit = int'(pwdata[THR_W-1:0]);
            if (in_valid && !in_stall)
                predict_item(in_item);
            if (!in_valid || !in_stall) begin
                if (item_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    in_valid <= 1'b1;
                    in_item  <= item_backlog.pop_front();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off on request
    always @(posedge clk) begin
        if (!rst_n) begin
            hold_left <= 0;
        end else if (hold_served != hold_asked) begin
            hold_left   <= HOLD_CYCLES;
            hold_served <= hold_asked;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // result monitor and output stall
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                if (expected_results.size() == 0) begin
                    $error("result with nothing expected: code %0d payload %h",
                           out_item.result_code, out_item.payload_res);
                    mismatches++;
                end else begin
                    want_r = expected_results.pop_front();
                    if (out_item.result_code !== want_r.result_code) begin
                        $error("result_code: expected %0d actual %0d",
                               want_r.result_code, out_item.result_code);
                        mismatches++;
                    end
                    if (out_item.payload_res !== want_r.payload_res) begin
                        $error("payload_res: expected %h actual %h",
                               want_r.payload_res, out_item.payload_res);
                        mismatches++;
                    end
                    if (out_item.live_count !== want_r.live_count) begin
                        $error("live_count: expected %0d actual %0d",
                               want_r.live_count, out_item.live_count);
                        mismatches++;
                    end
                    if (out_item.last !== want_r.last) begin
                        $error("last: expected %0d actual %0d", want_r.last, out_item.last);
                        mismatches++;
                    end
                end
            end
            out_stall <= (hold_left != 0) || ($urandom_range(99) < stall_pct);
        end
    end

    // run time limit
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL root_stack_mark_sweep_collector");
            $finish;
        end
    end

    task automatic apb_write(input logic [APB_ADDR_W-1:0] addr,
                             input logic [APB_DATA_W-1:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic queue_item(input rsmc_pkg::t_kind kind,
                              input logic [PAYLOAD_W-1:0] pay);
        rsmc_pkg::t_in_item it;
        it.kind    = kind;
        it.payload = pay;
        item_backlog.push_back(it);
    endtask

    // mostly pushes and pops, with some sweeps and releases
    task automatic queue_random(input int count);
        int              pick;
        int              pay_pick;
        rsmc_pkg::t_kind kind;
        for (int n = 0; n < count; n++) begin
            pick     = $urandom_range(99);
            pay_pick = $urandom_range(9);
            if (pick < 50)      kind = rsmc_pkg::K_PUSH;
            else if (pick < 82) kind = rsmc_pkg::K_POP;
            else if (pick < 91) kind = rsmc_pkg::K_COLLECT;
            else                kind = rsmc_pkg::K_RELEASE;
            queue_item(kind, (pay_pick == 0) ? '0 :
                             (pay_pick == 1) ? '1 : PAYLOAD_W'($urandom));
        end
    endtask

    task automatic wait_drained();
        do @(posedge clk);
        while (item_backlog.size() != 0 || in_valid || expected_results.size() != 0);
    endtask

    // stimulus
    initial begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // empty stack, full stack, pops and both sweep kinds at reset threshold
        send_idle_pct = 0;
        stall_pct     = 0;
        queue_item(rsmc_pkg::K_POP, '0);
        queue_item(rsmc_pkg::K_COLLECT, PAYLOAD_W'($urandom));
        for (int i = 0; i < STACK_DEPTH; i++)
            queue_item(rsmc_pkg::K_PUSH, (i == 0) ? '0 : (i == 1) ? '1 : PAYLOAD_W'($urandom));
        queue_item(rsmc_pkg::K_PUSH, PAYLOAD_W'($urandom));
        queue_item(rsmc_pkg::K_POP, '0);
        queue_item(rsmc_pkg::K_POP, '0);
        queue_item(rsmc_pkg::K_COLLECT, '0);
        queue_item(rsmc_pkg::K_RELEASE, '1);
        queue_item(rsmc_pkg::K_POP, '0);
        wait_drained();

        // threshold zero on an empty table, then unrooted objects fill it up
        send_idle_pct = 75;
        apb_write(SPARE_ADDR, 32'd3);
        apb_write(THR_ADDR, 32'd0);
        for (int i = 0; i < 36; i++) begin
            queue_item(rsmc_pkg::K_PUSH, PAYLOAD_W'($urandom));
            queue_item(rsmc_pkg::K_POP, '0);
        end
        queue_item(rsmc_pkg::K_RELEASE, '0);
        wait_drained();

        // top threshold, receiver stalls and holds off while items keep coming
        send_idle_pct = 0;
        stall_pct     = 75;
        apb_write(THR_ADDR, 32'd32);
        hold_asked++;
        queue_random(60);
        wait_drained();

        // both sides idle
        send_idle_pct = 38;
        stall_pct     = 38;
        apb_write(THR_ADDR, 32'd5);
        queue_random(60);
        wait_drained();

        // full rate
        send_idle_pct = 0;
        stall_pct     = 0;
        apb_write(THR_ADDR, 32'd26);
        queue_random(60);
        wait_drained();

        // sparse sender, random threshold
        send_idle_pct = 75;
        apb_write(THR_ADDR, APB_DATA_W'($urandom_range(32)));
        queue_random(55);
        wait_drained();

        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0) begin
            $display("PASS root_stack_mark_sweep_collector");
        end else begin
            $display("FAIL root_stack_mark_sweep_collector");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/rsmc_pkg.sv
hw/rtl/root_stack_mark_sweep_collector.sv
verif/root_stack_mark_sweep_collector_test.sv
